// File: design/vgpd_pkg.sv
`default_nettype none
package vgpd_pkg;

   // CRC-15 generator, seed and top-bit test
   localparam logic [15:0] CRC_POLY = 16'h4599;
   localparam logic [15:0] CRC_SEED = 16'h0010;
   localparam logic [15:0] CRC_TOP  = 16'h4000;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   // byte positions within a register group
   localparam logic [2:0] POS_FIRST  = 3'd0;
   localparam logic [2:0] POS_S0_HI  = 3'd1;
   localparam logic [2:0] POS_S1_HI  = 3'd3;
   localparam logic [2:0] POS_S2_HI  = 3'd5;
   localparam logic [2:0] POS_PEC_HI = 3'd6;
   localparam logic [2:0] POS_PEC_LO = 3'd7;

   // (raw + 5) / 10 as (raw + 5) * 52429 >> 19, exact for raw + 5 < 2^17
   localparam int          MV_WIDTH = 13;
   localparam logic [15:0] MV_RECIP = 16'd52429;
   localparam int          MV_SHIFT = 19;
   localparam logic [16:0] MV_ROUND = 17'd5;

   typedef logic [MV_WIDTH-1:0] mv_type;

   // one byte-wise CRC step, eight bit steps of the generator
   function automatic logic [15:0] crc_step(input logic [15:0] rem, input logic [7:0] b);
      logic [15:0] t;
      t = {1'b0, (rem[14:7] ^ b) & BYTE_MASK, 7'd0};
      for (int k = 0; k < 8; k++) begin
         if ((t & CRC_TOP) != 16'd0) begin
            t = {t[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            t = {t[14:0], 1'b0};
         end
      end
      return {rem[7:0], 8'd0} ^ t;
   endfunction

endpackage
`default_nettype wire

// File: design/vgpd_if.sv
`default_nettype none
// byte channel into the decoder
interface vgpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       group_start;

   modport source (output valid, output data_byte, output group_start, input ready);
   modport sink   (input valid, input data_byte, input group_start, output ready);
endinterface

// decoded group result channel
interface vgpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        pec_ok;
   logic [12:0] sample0_mv;
   logic [12:0] sample1_mv;
   logic [12:0] sample2_mv;

   modport source (output valid, output pec_ok, output sample0_mv, output sample1_mv,
                   output sample2_mv, input ready);
   modport sink   (input valid, input pec_ok, input sample0_mv, input sample1_mv,
                   input sample2_mv, output ready);
endinterface
`default_nettype wire

// File: design/vgpd_mv_conv.sv
`default_nettype none
// 100 uV raw sample to rounded millivolts
module vgpd_mv_conv (
   input  wire logic [15:0]     raw,
   output vgpd_pkg::mv_type     mv
);
   import vgpd_pkg::*;

   logic [16:0] sum;
   logic [32:0] prod;

   // reciprocal multiply replaces the divide by ten
   always_comb begin
      sum  = {1'b0, raw} + MV_ROUND;
      prod = {16'd0, sum} * {17'd0, MV_RECIP};
      mv   = prod[MV_SHIFT +: MV_WIDTH];
   end
endmodule
`default_nettype wire

// File: design/voltage_group_pec_decoder.sv
`default_nettype none
// Voltage register group PEC decoder.
// req_if carries one byte of an 8-byte register group per beat: three
// little-endian 16-bit samples (100 uV units) then a big-endian PEC. A beat
// with group_start high is taken as byte 0 and drops any partial group.
// The CRC-15 (poly 0x4599, seed 0x0010) advances one byte per payload beat, and each
// sample is converted to mV as soon as its high byte arrives, so the PEC
// byte only needs a compare and a select.
// rsp_if carries one beat per group: pec_ok and three samples in mV, all
// samples zero when the PEC does not match.
// Throughput: one byte per cycle while the receiver does not stall; the
// byte-wise CRC step is combinational. The result is valid the cycle after the last byte.
// A single output register holds the result; while it waits on a stalled
// receiver, no byte is taken at all, whatever its position in the group
// (ready is low whenever the output register is full and not being
// drained), so a stalled receiver holds up the byte stream.
// Reset (synchronous) returns the byte position to 0, the CRC to the seed
// and empties the output register.
module voltage_group_pec_decoder (
   input wire logic   clock,
   input wire logic   reset,
   vgpd_req_if.sink   req_if,
   vgpd_rsp_if.source rsp_if
);
   import vgpd_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  lo_ff;
   logic [7:0]  pec_hi_ff;
   mv_type      mv_ff [3];
   logic        rsp_valid_ff, rsp_valid_in;
   logic        pec_ok_ff;
   mv_type      s0_ff, s1_ff, s2_ff;

   logic        req_accept;
   logic [2:0]  pos_eff;
   logic [15:0] crc_eff;
   logic        pec_match;
   mv_type      mv_new;

   assign req_accept    = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;

   // start flag forces byte 0 and a fresh seed
   assign pos_eff = req_if.group_start ? POS_FIRST : pos_ff;
   assign crc_eff = req_if.group_start ? CRC_SEED : crc_ff;

   // sample conversion on the high byte of each sample
   vgpd_mv_conv u_conv (
      .raw ({req_if.data_byte, lo_ff}),
      .mv  (mv_new)
   );

   assign pec_match = ({pec_hi_ff, req_if.data_byte} == {crc_eff[14:0], 1'b0});

   // position and CRC update
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (req_accept) begin
         priority if (pos_eff == POS_PEC_LO) begin
            pos_in = POS_FIRST;
            crc_in = CRC_SEED;
         end else if (pos_eff == POS_PEC_HI) begin
            pos_in = POS_PEC_LO;
            crc_in = crc_eff;
         end else begin
            pos_in = pos_eff + 3'd1;
            crc_in = crc_step(crc_eff, req_if.data_byte);
         end
      end
   end

   // output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && pos_eff == POS_PEC_LO) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         crc_ff       <= CRC_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: low bytes, converted samples, PEC high byte, result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (pos_eff[0] == 1'b0) begin
            lo_ff <= req_if.data_byte;
         end
         if (pos_eff == POS_S0_HI) begin
            mv_ff[0] <= mv_new;
         end
         if (pos_eff == POS_S1_HI) begin
            mv_ff[1] <= mv_new;
         end
         if (pos_eff == POS_S2_HI) begin
            mv_ff[2] <= mv_new;
         end
         if (pos_eff == POS_PEC_HI) begin
            pec_hi_ff <= req_if.data_byte;
         end
         if (pos_eff == POS_PEC_LO) begin
            pec_ok_ff <= pec_match;
            s0_ff     <= pec_match ? mv_ff[0] : '0;
            s1_ff     <= pec_match ? mv_ff[1] : '0;
            s2_ff     <= pec_match ? mv_ff[2] : '0;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pec_ok     = pec_ok_ff;
   assign rsp_if.sample0_mv = s0_ff;
   assign rsp_if.sample1_mv = s1_ff;
   assign rsp_if.sample2_mv = s2_ff;

   // last byte of a group always yields a result beat
   a_result_after_pec: assert property (@(posedge clock) disable iff (reset)
      req_accept && pos_eff == POS_PEC_LO |=> rsp_valid_ff)
      else $error("no result after PEC byte");

   // a group end reseeds the CRC and rewinds the position
   a_reseed_after_group: assert property (@(posedge clock) disable iff (reset)
      req_accept && pos_eff == POS_PEC_LO |=> pos_ff == POS_FIRST && crc_ff == CRC_SEED)
      else $error("position or CRC not reset after group");

   // a failed check carries zero samples
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pec_ok_ff |-> s0_ff == '0 && s1_ff == '0 && s2_ff == '0)
      else $error("nonzero sample with failed PEC");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !req_accept)
      else $error("byte taken while result stalled");

endmodule
`default_nettype wire

// File: sim/vgpd_pec_calc_pkg.sv
// PEC arithmetic shared by the byte generator and the result predictor
package vgpd_pec_calc_pkg;

   import vgpd_pkg::*;

   // decoded group: check flag and three samples in mV
   typedef struct packed {
      logic   pec_ok;
      mv_type sample0_mv;
      mv_type sample1_mv;
      mv_type sample2_mv;
   } group_result_type;

   // CRC-15 over one byte, MSB first, one generator bit per step
   function automatic logic [14:0] crc15_advance(input logic [14:0] rem, input logic [7:0] b);
      logic [14:0] r;
      logic        fb;
      r = rem;
      for (int i = 7; i >= 0; i--) begin
         fb = r[14] ^ b[i];
         r  = {r[13:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY[14:0];
         end
      end
      return r;
   endfunction

   // PEC word as sent on the link for six payload bytes (byte k at bits 8k+7:8k)
   function automatic logic [15:0] pec_of_payload(input logic [47:0] payload);
      logic [14:0] r;
      r = CRC_SEED[14:0];
      for (int k = 0; k < 6; k++) begin
         r = crc15_advance(r, payload[8*k +: 8]);
      end
      return {r, 1'b0};
   endfunction

   // 100 uV units to mV, rounded to nearest
   function automatic mv_type raw_to_mv(input logic [15:0] raw);
      int v;
      v = (int'(raw) + 5) / 10;
      return mv_type'(v);
   endfunction

endpackage

// File: sim/vgpd_checker.sv
// Watches both channels, predicts each decoded group and compares results
module vgpd_checker (
   input  logic clock,
   input  logic reset,
   vgpd_req_if  req_mon,
   vgpd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_groups
);
   import vgpd_pkg::*;
   import vgpd_pec_calc_pkg::*;

   // predicted decoder state
   logic [2:0]       byte_pos;
   logic [14:0]      crc_rem;
   logic [47:0]      payload;
   logic [7:0]       pec_hi;
   group_result_type expected_groups[$];

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   initial begin
      fail_count     = 0;
      pending_groups = 0;
   end

   always @(posedge clock) begin
      group_result_type exp_r;
      logic [15:0]      rx_pec;
      logic             ok;
      if (reset) begin
         byte_pos = POS_FIRST;
         crc_rem  = CRC_SEED[14:0];
         expected_groups.delete();
      end else begin
         // result beat: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_groups.size() == 0) begin
               $error("result beat with no group pending");
               fail_count++;
            end else begin
               exp_r = expected_groups.pop_front();
               check_field("pec_ok", exp_r.pec_ok, rsp_mon.pec_ok);
               check_field("sample0_mv", exp_r.sample0_mv, rsp_mon.sample0_mv);
               check_field("sample1_mv", exp_r.sample1_mv, rsp_mon.sample1_mv);
               check_field("sample2_mv", exp_r.sample2_mv, rsp_mon.sample2_mv);
            end
         end
         // byte beat: advance the predicted group
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.group_start) begin
               byte_pos = POS_FIRST;
               crc_rem  = CRC_SEED[14:0];
            end
            if (byte_pos < POS_PEC_HI) begin
               payload[8*byte_pos +: 8] = req_mon.data_byte;
               crc_rem  = crc15_advance(crc_rem, req_mon.data_byte);
               byte_pos = byte_pos + 3'd1;
            end else if (byte_pos == POS_PEC_HI) begin
               pec_hi   = req_mon.data_byte;
               byte_pos = POS_PEC_LO;
            end else begin
               rx_pec = {pec_hi, req_mon.data_byte};
               ok     = (rx_pec == {crc_rem, 1'b0});
               exp_r.pec_ok     = ok;
               exp_r.sample0_mv = ok ? raw_to_mv(payload[15:0])  : '0;
               exp_r.sample1_mv = ok ? raw_to_mv(payload[31:16]) : '0;
               exp_r.sample2_mv = ok ? raw_to_mv(payload[47:32]) : '0;
               expected_groups.push_back(exp_r);
               byte_pos = POS_FIRST;
               crc_rem  = CRC_SEED[14:0];
            end
         end
      end
      pending_groups = expected_groups.size();
   end

endmodule

// File: sim/tb_voltage_group_pec_decoder.sv
// Byte stimulus and verdict for the voltage group PEC decoder
module tb_voltage_group_pec_decoder;
   import vgpd_pkg::*;
   import vgpd_pec_calc_pkg::*;

   localparam int RANDOM_BYTES  = 550;
   localparam int RUN_LIMIT     = 800000;
   localparam int DRAIN_CYCLES  = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_groups;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   bytes_sent;

   vgpd_req_if req_bus ();
   vgpd_rsp_if rsp_bus ();

   voltage_group_pec_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   vgpd_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .pending_groups (pending_groups)
   );

   // clock, period 4
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // hard stop
   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // one byte beat, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.group_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // first n_bytes of a register group; pec_flip corrupts the PEC
   task automatic send_group(input logic [15:0] s0, input logic [15:0] s1,
                             input logic [15:0] s2, input logic start,
                             input logic [15:0] pec_flip, input int n_bytes);
      logic [63:0] grp;
      logic [15:0] pec;
      pec = pec_of_payload({s2, s1, s0}) ^ pec_flip;
      grp = {pec[7:0], pec[15:8], s2, s1, s0};
      for (int k = 0; k < n_bytes; k++) begin
         send_byte(grp[8*k +: 8], (k == 0) ? start : 1'b0);
      end
   endtask

   // mostly uniform samples, some at the range ends
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'($urandom_range(0, 9));
      return 16'($urandom);
   endfunction

   initial begin
      int  kind;
      int  n;
      logic need_start;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.group_start = 1'b0;
      tx_idle_pct         = 28;
      rx_idle_pct         = 55;
      bytes_sent          = 0;
      need_start          = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: full-scale samples
      send_group(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 8);
      // next group follows without a start flag; rounding edges
      send_group(16'h0000, 16'h0005, 16'h0004, 1'b0, 16'h0000, 8);
      // partial group, then a restart mid-group with a bad PEC
      send_group(16'h1234, 16'hABCD, 16'h8000, 1'b0, 16'h0000, 3);
      send_group(16'h7FFF, 16'h0010, 16'hFFF6, 1'b1, 16'h0100, 8);

      // random groups, mostly well formed
      while (bytes_sent < RANDOM_BYTES) begin
         if (bytes_sent < 200) begin
            tx_idle_pct = 28;
            rx_idle_pct = 55;
         end else if (bytes_sent < 400) begin
            tx_idle_pct = 55;
            rx_idle_pct = 28;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            send_group(pick_sample(), pick_sample(), pick_sample(),
                       need_start | 1'($urandom_range(0, 1)), 16'h0000, 8);
            need_start = 1'b0;
         end else if (kind < 87) begin
            send_group(pick_sample(), pick_sample(), pick_sample(),
                       need_start | 1'($urandom_range(0, 1)),
                       16'(1 << $urandom_range(0, 15)), 8);
            need_start = 1'b0;
         end else if (kind < 95) begin
            // truncated group
            n = $urandom_range(1, 7);
            send_group(pick_sample(), pick_sample(), pick_sample(),
                       1'($urandom_range(0, 1)), 16'h0000, n);
            need_start = 1'b1;
         end else begin
            // raw noise with stray start flags
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end
            need_start = 1'b1;
         end
      end
      req_bus.valid <= 1'b0;

      // drain outstanding results, then let the pipeline settle
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (pending_groups != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
design/vgpd_pkg.sv
design/vgpd_if.sv
design/vgpd_mv_conv.sv
design/voltage_group_pec_decoder.sv
sim/vgpd_pec_calc_pkg.sv
sim/vgpd_checker.sv
sim/tb_voltage_group_pec_decoder.sv
